FILE: rtl/ldwc_pkg.sv
// Shared types and constants for the linked deque with cursor.
package ldwc_pkg;

    localparam int NODE_COUNT_DEF = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 4;
    localparam int STATUS_W       = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RESTART    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_NEXT       = 4'd7;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd9;
    localparam logic [CMD_W-1:0] CMD_REPLACE    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_READ       = 4'd11;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BEFORE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FETCH  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic take;
        logic give;
    } free_ctl_t;

endpackage

FILE: rtl/ldwc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ldwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ldwc_free.sv
// Free node allocator: a fresh-node counter backed by a stack of returned nodes.
module ldwc_free #(
    parameter int NODE_COUNT = ldwc_pkg::NODE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_req,
    input  ldwc_pkg::free_ctl_t           ctl,
    input  logic [$clog2(NODE_COUNT)-1:0] give_idx,
    output logic [$clog2(NODE_COUNT)-1:0] alloc_idx
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int PW = $clog2(NODE_COUNT + 1);

    logic [PW-1:0] top_reg, top_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    logic [PW-1:0] top_dec;
    logic [IW-1:0] stk_rdata;

    assign top_dec = top_reg - PW'(1);

    // Returned nodes are reused first; never-used nodes come from the counter.
    assign alloc_idx = (top_reg != '0) ? stk_rdata : fresh_reg[IW-1:0];

    always_comb
    begin
        top_next   = top_reg;
        fresh_next = fresh_reg;
        if (ctl.take)
        begin
            if (top_reg != '0)
            begin
                top_next = top_dec;
            end
            else
            begin
                fresh_next = fresh_reg + PW'(1);
            end
        end
        else if (ctl.give)
        begin
            top_next = top_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            top_reg   <= top_next;
            fresh_reg <= fresh_next;
        end
    end

    ldwc_ram #(
        .WIDTH (IW),
        .DEPTH (NODE_COUNT)
    ) u_stack (
        .clk   (clk),
        .we    (ctl.give),
        .waddr (top_reg[IW-1:0]),
        .wdata (give_idx),
        .re    (rd_req),
        .raddr (top_dec[IW-1:0]),
        .rdata (stk_rdata)
    );

endmodule

FILE: rtl/linked_deque_with_cursor.sv
// Top level of the linked deque with cursor: command sequencer and node store.
//
//  Channel   Signals                         Direction  Handshake
//  -------   ------------------------------  ---------  -------------------------------
//  command   start, cmd, data_in, busy       in         taken when start=1 and busy=0
//  result    done, data_out, data_valid,     out        done strobes one cycle, no stall
//            status, length, cursor_at_end
//
// Most commands pass through the fetch state only: the accept edge launches
// the node store reads, the fetch state performs the writes and registers the
// result, which is shown while a new command can already be taken. A next that
// lands on an item and a general insert also pass the finish state: next needs
// a chained read of the link memory and then the data memory, insert needs a
// second write to each link memory. A next that ends up at end finishes from fetch.
// Reset is asynchronous and active low and leaves an empty deque with the cursor
// at end; no clearing pass is needed. The receiver cannot stall results.
module linked_deque_with_cursor #(
    parameter int NODE_COUNT = ldwc_pkg::NODE_COUNT_DEF,
    parameter int DATA_WIDTH = ldwc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ldwc_pkg::CMD_W-1:0]           cmd,
    input  logic [DATA_WIDTH-1:0]                data_in,
    output logic                                 busy,
    output logic                                 done,
    output logic [DATA_WIDTH-1:0]                data_out,
    output logic                                 data_valid,
    output logic [ldwc_pkg::STATUS_W-1:0]        status,
    output logic [$clog2(NODE_COUNT + 1)-1:0]    length,
    output logic                                 cursor_at_end
);

    // Node indices use IW bits; pointers use PW bits so that NODE_COUNT can
    // serve as the null pointer.
    localparam int IW = $clog2(NODE_COUNT);
    localparam int PW = $clog2(NODE_COUNT + 1);
    localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

    ldwc_pkg::state_t state_reg, state_next;

    logic [ldwc_pkg::CMD_W-1:0] cmd_reg;
    logic [DATA_WIDTH-1:0]      din_reg;
    logic [PW-1:0]              head_reg, head_next;
    logic [PW-1:0]              tail_reg, tail_next;
    logic [PW-1:0]              cursor_reg, cursor_next;
    logic                       bs_reg, bs_next;
    logic [PW-1:0]              count_reg, count_next;
    logic [IW-1:0]              node_reg, node_next;
    logic [IW-1:0]              link_reg, link_next;

    logic                          done_reg;
    logic [DATA_WIDTH-1:0]         data_out_reg;
    logic                          data_valid_reg;
    logic [ldwc_pkg::STATUS_W-1:0] status_reg;
    logic [PW-1:0]                 length_reg;
    logic                          at_end_reg;

    logic                          accept;
    logic                          res_fire;
    logic                          res_valid;
    logic [ldwc_pkg::STATUS_W-1:0] res_status;
    logic                          pb;
    logic                          pf;
    logic                          empty;
    logic                          full;

    // Node store ports.
    logic                  dat_we, dat_re;
    logic [IW-1:0]         dat_waddr, dat_raddr;
    logic [DATA_WIDTH-1:0] dat_wdata, dat_rdata;
    logic                  fwd_we, bwd_we;
    logic [IW-1:0]         fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
    logic [IW-1:0]         bwd_waddr, bwd_wdata, bwd_raddr, bwd_rdata;

    ldwc_pkg::free_ctl_t fctl;
    logic [IW-1:0]       give_idx;
    logic [IW-1:0]       alloc_idx;
    logic [PW-1:0]       alloc_p;

    // Links of the cursor node. The ends of the list are never stored in the
    // link memories: the head has no predecessor and the tail no successor.
    logic [PW-1:0] cur_prev;
    logic [PW-1:0] cur_next;
    logic [PW-1:0] nxt_cur;

    assign accept  = start && (state_reg == ldwc_pkg::S_IDLE);
    assign busy    = (state_reg != ldwc_pkg::S_IDLE);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == NIL);
    assign alloc_p = PW'(alloc_idx);

    assign cur_prev = (cursor_reg == head_reg) ? NIL : PW'(bwd_rdata);
    assign cur_next = (cursor_reg == tail_reg) ? NIL : PW'(fwd_rdata);
    assign nxt_cur  = bs_reg ? head_reg : ((cursor_reg != NIL) ? cur_next : NIL);

    // Read addresses are launched at the accept edge; a next command launches
    // its data read once the successor link has come back.
    always_comb
    begin
        dat_raddr = cursor_reg[IW-1:0];
        fwd_raddr = cursor_reg[IW-1:0];
        bwd_raddr = cursor_reg[IW-1:0];
        if (state_reg == ldwc_pkg::S_FETCH)
        begin
            dat_raddr = nxt_cur[IW-1:0];
        end
        else if ((cmd == ldwc_pkg::CMD_POP_BACK) || (cmd == ldwc_pkg::CMD_PEEK_BACK))
        begin
            dat_raddr = tail_reg[IW-1:0];
            bwd_raddr = tail_reg[IW-1:0];
        end
        else if ((cmd == ldwc_pkg::CMD_POP_FRONT) || (cmd == ldwc_pkg::CMD_PEEK_FRONT))
        begin
            dat_raddr = head_reg[IW-1:0];
            fwd_raddr = head_reg[IW-1:0];
        end
    end

    assign dat_re = accept ||
                    ((state_reg == ldwc_pkg::S_FETCH) && (cmd_reg == ldwc_pkg::CMD_NEXT));

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        bs_next     = bs_reg;
        count_next  = count_reg;
        node_next   = node_reg;
        link_next   = link_reg;
        res_fire    = 1'b0;
        res_valid   = 1'b0;
        res_status  = ldwc_pkg::STAT_OK;
        pb          = 1'b0;
        pf          = 1'b0;
        fctl        = '0;
        give_idx    = '0;
        dat_we      = 1'b0;
        dat_waddr   = alloc_idx;
        dat_wdata   = din_reg;
        fwd_we      = 1'b0;
        fwd_waddr   = alloc_idx;
        fwd_wdata   = alloc_idx;
        bwd_we      = 1'b0;
        bwd_waddr   = alloc_idx;
        bwd_wdata   = alloc_idx;

        unique case (state_reg)
            ldwc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ldwc_pkg::S_FETCH;
                end
            end

            ldwc_pkg::S_FETCH:
            begin
                state_next = ldwc_pkg::S_IDLE;
                res_fire   = 1'b1;
                unique case (cmd_reg)
                    ldwc_pkg::CMD_PUSH_BACK:
                    begin
                        pb = 1'b1;
                    end
                    ldwc_pkg::CMD_PUSH_FRONT:
                    begin
                        pf = 1'b1;
                    end
                    ldwc_pkg::CMD_POP_BACK, ldwc_pkg::CMD_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            res_status = ldwc_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            count_next = count_reg - PW'(1);
                            fctl.give  = 1'b1;
                            if (cmd_reg == ldwc_pkg::CMD_POP_BACK)
                            begin
                                give_idx = tail_reg[IW-1:0];
                                if (cursor_reg == tail_reg)
                                begin
                                    cursor_next = NIL;
                                    bs_next     = 1'b0;
                                end
                            end
                            else
                            begin
                                give_idx = head_reg[IW-1:0];
                                if (cursor_reg == head_reg)
                                begin
                                    cursor_next = NIL;
                                    bs_next     = 1'b0;
                                end
                            end
                            if (head_reg == tail_reg)
                            begin
                                head_next = NIL;
                                tail_next = NIL;
                            end
                            else if (cmd_reg == ldwc_pkg::CMD_POP_BACK)
                            begin
                                tail_next = PW'(bwd_rdata);
                            end
                            else
                            begin
                                head_next = PW'(fwd_rdata);
                            end
                        end
                    end
                    ldwc_pkg::CMD_PEEK_BACK, ldwc_pkg::CMD_PEEK_FRONT:
                    begin
                        if (empty)
                        begin
                            res_status = ldwc_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                        end
                    end
                    ldwc_pkg::CMD_RESTART:
                    begin
                        cursor_next = head_reg;
                        bs_next     = 1'b0;
                    end
                    ldwc_pkg::CMD_NEXT:
                    begin
                        cursor_next = nxt_cur;
                        bs_next     = 1'b0;
                        if (nxt_cur != NIL)
                        begin
                            // The word under the new cursor arrives next cycle.
                            res_fire   = 1'b0;
                            state_next = ldwc_pkg::S_FINISH;
                        end
                        else
                        begin
                            res_status = ldwc_pkg::STAT_EMPTY;
                        end
                    end
                    ldwc_pkg::CMD_INSERT:
                    begin
                        priority if (bs_reg)
                        begin
                            res_status = ldwc_pkg::STAT_BEFORE;
                        end
                        else if (cursor_reg == head_reg)
                        begin
                            pf = 1'b1;
                        end
                        else if (cursor_reg == NIL)
                        begin
                            pb = 1'b1;
                        end
                        else if (full)
                        begin
                            res_status = ldwc_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // Link the new node both ways now; its neighbors
                            // are pointed at it in the finish cycle.
                            fctl.take  = 1'b1;
                            dat_we     = 1'b1;
                            fwd_we     = 1'b1;
                            fwd_wdata  = cursor_reg[IW-1:0];
                            bwd_we     = 1'b1;
                            bwd_wdata  = cur_prev[IW-1:0];
                            count_next = count_reg + PW'(1);
                            node_next  = alloc_idx;
                            link_next  = cur_prev[IW-1:0];
                            res_fire   = 1'b0;
                            state_next = ldwc_pkg::S_FINISH;
                        end
                    end
                    ldwc_pkg::CMD_REMOVE, ldwc_pkg::CMD_REPLACE, ldwc_pkg::CMD_READ:
                    begin
                        priority if (bs_reg)
                        begin
                            res_status = ldwc_pkg::STAT_BEFORE;
                        end
                        else if (cursor_reg == NIL)
                        begin
                            res_status = ldwc_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            if (cmd_reg == ldwc_pkg::CMD_REPLACE)
                            begin
                                dat_we    = 1'b1;
                                dat_waddr = cursor_reg[IW-1:0];
                            end
                            else if (cmd_reg == ldwc_pkg::CMD_REMOVE)
                            begin
                                count_next = count_reg - PW'(1);
                                fctl.give  = 1'b1;
                                give_idx   = cursor_reg[IW-1:0];
                                if (cur_prev != NIL)
                                begin
                                    cursor_next = cur_prev;
                                    if (cur_next != NIL)
                                    begin
                                        fwd_we    = 1'b1;
                                        fwd_waddr = cur_prev[IW-1:0];
                                        fwd_wdata = cur_next[IW-1:0];
                                        bwd_we    = 1'b1;
                                        bwd_waddr = cur_next[IW-1:0];
                                        bwd_wdata = cur_prev[IW-1:0];
                                    end
                                    else
                                    begin
                                        tail_next = cur_prev;
                                    end
                                end
                                else
                                begin
                                    // Removing the first item leaves the cursor
                                    // before the start.
                                    cursor_next = NIL;
                                    bs_next     = 1'b1;
                                    head_next   = cur_next;
                                    if (tail_reg == cursor_reg)
                                    begin
                                        tail_next = cur_next;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (pb || pf)
                begin
                    if (full)
                    begin
                        res_status = ldwc_pkg::STAT_FULL;
                    end
                    else
                    begin
                        fctl.take  = 1'b1;
                        dat_we     = 1'b1;
                        count_next = count_reg + PW'(1);
                        if (pb)
                        begin
                            tail_next = alloc_p;
                            if (empty)
                            begin
                                head_next = alloc_p;
                            end
                            else
                            begin
                                bwd_we    = 1'b1;
                                bwd_wdata = tail_reg[IW-1:0];
                                fwd_we    = 1'b1;
                                fwd_waddr = tail_reg[IW-1:0];
                            end
                        end
                        else
                        begin
                            head_next = alloc_p;
                            if (empty)
                            begin
                                tail_next = alloc_p;
                            end
                            else
                            begin
                                fwd_we    = 1'b1;
                                fwd_wdata = head_reg[IW-1:0];
                                bwd_we    = 1'b1;
                                bwd_waddr = head_reg[IW-1:0];
                            end
                        end
                    end
                end
            end

            ldwc_pkg::S_FINISH:
            begin
                state_next = ldwc_pkg::S_IDLE;
                res_fire   = 1'b1;
                if (cmd_reg == ldwc_pkg::CMD_NEXT)
                begin
                    res_valid = 1'b1;
                end
                else
                begin
                    // Second half of an insert: predecessor and cursor node
                    // now point at the new node.
                    fwd_we    = 1'b1;
                    fwd_waddr = link_reg;
                    fwd_wdata = node_reg;
                    bwd_we    = 1'b1;
                    bwd_waddr = cursor_reg[IW-1:0];
                    bwd_wdata = node_reg;
                end
            end

            default:
            begin
                state_next = ldwc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ldwc_pkg::S_IDLE;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            cursor_reg <= NIL;
            bs_reg     <= 1'b0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            bs_reg     <= bs_next;
            count_reg  <= count_next;
            done_reg   <= res_fire;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            din_reg <= data_in;
        end
        node_reg <= node_next;
        link_reg <= link_next;
        if (res_fire)
        begin
            data_out_reg   <= res_valid ? dat_rdata : '0;
            data_valid_reg <= res_valid;
            status_reg     <= res_status;
            length_reg     <= count_next;
            at_end_reg     <= !bs_next && (cursor_next == NIL);
        end
    end

    assign done          = done_reg;
    assign data_out      = data_out_reg;
    assign data_valid    = data_valid_reg;
    assign status        = status_reg;
    assign length        = length_reg;
    assign cursor_at_end = at_end_reg;

    ldwc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NODE_COUNT)
    ) u_data (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .re    (dat_re),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    ldwc_ram #(
        .WIDTH (IW),
        .DEPTH (NODE_COUNT)
    ) u_fwd (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .re    (accept),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    ldwc_ram #(
        .WIDTH (IW),
        .DEPTH (NODE_COUNT)
    ) u_bwd (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .re    (accept),
        .raddr (bwd_raddr),
        .rdata (bwd_rdata)
    );

    ldwc_free #(
        .NODE_COUNT (NODE_COUNT)
    ) u_free (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_req    (accept),
        .ctl       (fctl),
        .give_idx  (give_idx),
        .alloc_idx (alloc_idx)
    );

    // A result only follows a cycle in which a command was being worked on.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != ldwc_pkg::S_IDLE))
        else $error("result strobe without a command in flight");

    // An empty deque has no head and no tail.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> ((head_reg == NIL) && (tail_reg == NIL)))
        else $error("empty deque with a live end pointer");

    // The item count never passes the size of the node store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("item count beyond node store size");

    // A before-start cursor is never reported as being at end.
    a_before_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ldwc_pkg::STAT_BEFORE)) |-> !at_end_reg)
        else $error("cursor before start reported at end");

endmodule

FILE: test/linked_deque_with_cursor_tb.sv
// Self-checking testbench for the linked deque with cursor, with its own prediction of each result.
module linked_deque_with_cursor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ldwc_pkg::*;

    localparam int NODES = NODE_COUNT_DEF;
    localparam int LEN_W = $clog2(NODES + 1);
    localparam logic [4:0] NIL = 5'(NODES);
    localparam int RANDOM_ITEMS = 900;
    // Cycles with neither a command nor a result accepted before the run is
    // abandoned. A sender gap that long is far beyond anything the random idling
    // produces.
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [31:0]      word;
    } command_t;

    typedef struct packed {
        logic [31:0]         word;
        logic                word_valid;
        logic [STATUS_W-1:0] stat;
        logic [LEN_W-1:0]    len;
        logic                at_end;
    } reply_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_CURSOR, MODE_MIXED} burst_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [CMD_W-1:0]     cmd = '0;
    logic [31:0]          data_in = '0;
    logic                 busy;
    logic                 done;
    logic [31:0]          data_out;
    logic                 data_valid;
    logic [STATUS_W-1:0]  status;
    logic [LEN_W-1:0]     length;
    logic                 cursor_at_end;

    command_t pending_commands[$];
    reply_t   predicted_replies[$];
    int       commands_total = 0;
    int       commands_taken = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;

    // Shadow copy of the deque: node store, free stack, ends, length and cursor.
    logic [31:0] node_word [NODES];
    logic [4:0]  node_fwd [NODES];
    logic [4:0]  node_back [NODES];
    logic [3:0]  spare_stack [NODES];
    logic [4:0]  spare_count;
    logic [4:0]  head_idx;
    logic [4:0]  tail_idx;
    logic [4:0]  held;
    logic [4:0]  cursor;
    logic        cursor_pre;

    linked_deque_with_cursor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .data_in      (data_in),
        .busy         (busy),
        .done         (done),
        .data_out     (data_out),
        .data_valid   (data_valid),
        .status       (status),
        .length       (length),
        .cursor_at_end(cursor_at_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Link accessors treat the null code as a node with no neighbors and no word.
    function automatic logic [4:0] fwd_of(logic [4:0] i);
        return (i < NODES) ? node_fwd[i[3:0]] : NIL;
    endfunction

    function automatic logic [4:0] back_of(logic [4:0] i);
        return (i < NODES) ? node_back[i[3:0]] : NIL;
    endfunction

    function automatic logic [31:0] word_of(logic [4:0] i);
        return (i < NODES) ? node_word[i[3:0]] : '0;
    endfunction

    function automatic void set_fwd(logic [4:0] i, logic [4:0] v);
        if (i < NODES)
            node_fwd[i[3:0]] = v;
    endfunction

    function automatic void set_back(logic [4:0] i, logic [4:0] v);
        if (i < NODES)
            node_back[i[3:0]] = v;
    endfunction

    // Takes a node off the free stack and fills it, or returns the null code when full.
    function automatic logic [4:0] alloc_node(logic [31:0] w);
        logic [4:0] n;
        if (spare_count == 0)
            return NIL;
        spare_count = spare_count - 5'd1;
        n = {1'b0, spare_stack[spare_count[3:0]]};
        node_word[n[3:0]] = w;
        node_fwd[n[3:0]] = NIL;
        node_back[n[3:0]] = NIL;
        return n;
    endfunction

    function automatic void recycle_node(logic [4:0] n);
        if (n < NODES && spare_count < NODES)
        begin
            spare_stack[spare_count[3:0]] = n[3:0];
            spare_count = spare_count + 5'd1;
        end
    endfunction

    function automatic logic [STATUS_W-1:0] append(logic [31:0] w);
        logic [4:0] n;
        n = alloc_node(w);
        if (n == NIL)
            return STAT_FULL;
        if (held == 0)
            head_idx = n;
        else
        begin
            set_back(n, tail_idx);
            set_fwd(tail_idx, n);
        end
        tail_idx = n;
        held = held + 5'd1;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] prepend(logic [31:0] w);
        logic [4:0] n;
        n = alloc_node(w);
        if (n == NIL)
            return STAT_FULL;
        if (held == 0)
            tail_idx = n;
        else
        begin
            set_fwd(n, head_idx);
            set_back(head_idx, n);
        end
        head_idx = n;
        held = held + 5'd1;
        return STAT_OK;
    endfunction

    // Applies one command to the shadow deque and returns the result it must produce.
    function automatic reply_t next_reply(command_t c);
        reply_t     r;
        logic [4:0] n;
        logic [4:0] p;
        logic [4:0] nx;
        r = '0;
        r.stat = STAT_OK;
        case (c.op)
            CMD_PUSH_BACK:
                r.stat = append(c.word);
            CMD_PUSH_FRONT:
                r.stat = prepend(c.word);
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (held == 0)
                    r.stat = STAT_EMPTY;
                else
                begin
                    n = (c.op == CMD_POP_BACK) ? tail_idx : head_idx;
                    r.word = word_of(n);
                    r.word_valid = 1'b1;
                    if (head_idx == tail_idx)
                    begin
                        head_idx = NIL;
                        tail_idx = NIL;
                    end
                    else if (c.op == CMD_POP_BACK)
                    begin
                        tail_idx = back_of(n);
                        set_fwd(tail_idx, NIL);
                    end
                    else
                    begin
                        head_idx = fwd_of(n);
                        set_back(head_idx, NIL);
                    end
                    held = held - 5'd1;
                    // Popping the node under the cursor parks the cursor at end.
                    if (cursor == n)
                    begin
                        cursor = NIL;
                        cursor_pre = 1'b0;
                    end
                    recycle_node(n);
                end
            end
            CMD_PEEK_BACK, CMD_PEEK_FRONT:
            begin
                if (held == 0)
                    r.stat = STAT_EMPTY;
                else
                begin
                    r.word = word_of((c.op == CMD_PEEK_BACK) ? tail_idx : head_idx);
                    r.word_valid = 1'b1;
                end
            end
            CMD_RESTART:
            begin
                cursor = head_idx;
                cursor_pre = 1'b0;
            end
            CMD_NEXT:
            begin
                // From before start this behaves like a restart.
                if (cursor_pre)
                begin
                    cursor = head_idx;
                    cursor_pre = 1'b0;
                end
                else if (cursor != NIL)
                    cursor = fwd_of(cursor);
                if (cursor != NIL)
                begin
                    r.word = word_of(cursor);
                    r.word_valid = 1'b1;
                end
                else
                    r.stat = STAT_EMPTY;
            end
            CMD_INSERT:
            begin
                if (cursor_pre)
                    r.stat = STAT_BEFORE;
                else if (cursor == head_idx)
                    r.stat = prepend(c.word);
                else if (cursor == NIL)
                    r.stat = append(c.word);
                else
                begin
                    n = alloc_node(c.word);
                    if (n == NIL)
                        r.stat = STAT_FULL;
                    else
                    begin
                        p = back_of(cursor);
                        set_back(n, p);
                        set_fwd(n, cursor);
                        set_fwd(p, n);
                        set_back(cursor, n);
                        held = held + 5'd1;
                    end
                end
            end
            CMD_REMOVE, CMD_REPLACE, CMD_READ:
            begin
                if (cursor_pre)
                    r.stat = STAT_BEFORE;
                else if (cursor == NIL)
                    r.stat = STAT_EMPTY;
                else
                begin
                    r.word = word_of(cursor);
                    r.word_valid = 1'b1;
                    if (c.op == CMD_REMOVE)
                    begin
                        n = cursor;
                        p = back_of(n);
                        nx = fwd_of(n);
                        if (p != NIL)
                        begin
                            cursor = p;
                            set_fwd(p, nx);
                            if (nx != NIL)
                                set_back(nx, p);
                            else
                                tail_idx = p;
                        end
                        else
                        begin
                            // Removing the first item leaves the cursor before start.
                            cursor = NIL;
                            cursor_pre = 1'b1;
                            head_idx = nx;
                            if (nx != NIL)
                                set_back(nx, NIL);
                            if (tail_idx == n)
                                tail_idx = head_idx;
                        end
                        held = held - 5'd1;
                        recycle_node(n);
                    end
                    else if (c.op == CMD_REPLACE)
                        node_word[cursor[3:0]] = c.word;
                end
            end
            default:
            begin
                // Unused codes leave everything alone.
            end
        endcase
        r.len = held[LEN_W-1:0];
        r.at_end = !cursor_pre && cursor == NIL;
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches = mismatches + 1;
    endtask

    task automatic queue_command(logic [CMD_W-1:0] op, logic [31:0] word);
        command_t c;
        c.op = op;
        c.word = word;
        pending_commands.push_back(c);
    endtask

    // Chooses a command; the fill, drain and cursor burst modes lean toward filling, draining or cursor work.
    function automatic logic [CMD_W-1:0] pick_op(burst_mode_t mode);
        int roll;
        int which;
        roll = $urandom_range(99);
        which = $urandom_range(6);
        if (roll < 2)
            return CMD_W'($urandom_range(CMD_READ + 1, (1 << CMD_W) - 1));
        case (mode)
            MODE_FILL:
                if (roll < 70)
                    return (which < 3) ? CMD_PUSH_BACK : (which < 5) ? CMD_PUSH_FRONT : CMD_INSERT;
            MODE_DRAIN:
                if (roll < 65)
                    return (which < 3) ? CMD_POP_BACK : (which < 5) ? CMD_POP_FRONT : CMD_REMOVE;
            MODE_CURSOR:
                if (roll < 75)
                begin
                    case (which)
                        0: return CMD_RESTART;
                        1, 2: return CMD_NEXT;
                        3: return CMD_READ;
                        4: return CMD_REPLACE;
                        5: return CMD_INSERT;
                        default: return CMD_REMOVE;
                    endcase
                end
            default:
            begin
            end
        endcase
        return CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_READ));
    endfunction

    // Driver: presents the next pending command, holds it while the block is busy,
    // and hands every accepted item to the predictor at its accept edge. The
    // sender idles at 29 percent for the first third, 56 percent for the second
    // third and never in the last third.
    always @(posedge clk)
    begin : drive_commands
        command_t shown;
        command_t c;
        int       idle_pct;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                shown.op = cmd;
                shown.word = data_in;
                predicted_replies.push_back(next_reply(shown));
                commands_taken = commands_taken + 1;
            end
            if (commands_taken < commands_total / 3)
                idle_pct = 29;
            else if (commands_taken < 2 * commands_total / 3)
                idle_pct = 56;
            else
                idle_pct = 0;
            if (!start || !busy)
            begin
                if (pending_commands.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    c = pending_commands.pop_front();
                    start <= 1'b1;
                    cmd <= c.op;
                    data_in <= c.word;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe is matched against the oldest predicted result.
    always @(posedge clk)
    begin : check_results
        reply_t want;
        if (rst_n && done)
        begin
            if (predicted_replies.size() == 0)
                flag_mismatch("result with no command outstanding");
            else
            begin
                want = predicted_replies.pop_front();
                if (data_out !== want.word)
                    flag_mismatch($sformatf("data_out %h, expected %h", data_out, want.word));
                if (data_valid !== want.word_valid)
                    flag_mismatch($sformatf("data_valid %b, expected %b",
                                            data_valid, want.word_valid));
                if (status !== want.stat)
                    flag_mismatch($sformatf("status %0d, expected %0d", status, want.stat));
                if (length !== want.len)
                    flag_mismatch($sformatf("length %0d, expected %0d", length, want.len));
                if (cursor_at_end !== want.at_end)
                    flag_mismatch($sformatf("cursor_at_end %b, expected %b",
                                            cursor_at_end, want.at_end));
            end
        end
    end

    // Watchdog: gives up when neither a command nor a result moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        burst_mode_t      mode;
        logic [CMD_W-1:0] op;
        logic [31:0]      word;
        int               counted;
        int               roll;

        // The shadow deque starts empty with every node on the free stack.
        for (int i = 0; i < NODES; i++)
        begin
            node_word[i] = '0;
            node_fwd[i] = '0;
            node_back[i] = '0;
            spare_stack[i] = 4'(i);
        end
        spare_count = 5'(NODES);
        head_idx = NIL;
        tail_idx = NIL;
        held = '0;
        cursor = NIL;
        cursor_pre = 1'b0;

        // Directed part: empty-deque errors, insert into an empty deque, a general
        // insert, replace and read, removal both mid-list and of the first item,
        // cursor commands from before start, popping the node under the cursor,
        // insert at end, and the unused codes.
        queue_command(CMD_PEEK_FRONT, 32'h0);
        queue_command(CMD_POP_BACK, 32'h0);
        queue_command(CMD_POP_FRONT, 32'h0);
        queue_command(CMD_NEXT, 32'h0);
        queue_command(CMD_READ, 32'h0);
        queue_command(CMD_REMOVE, 32'h0);
        queue_command(CMD_INSERT, 32'hFFFF_FFFF);
        queue_command(CMD_PUSH_BACK, 32'h0000_0000);
        queue_command(CMD_PUSH_FRONT, 32'h8000_0000);
        queue_command(CMD_RESTART, 32'h0);
        queue_command(CMD_NEXT, 32'h0);
        queue_command(CMD_INSERT, 32'h0000_0001);
        queue_command(CMD_REPLACE, 32'hAAAA_AAAA);
        queue_command(CMD_READ, 32'h0);
        queue_command(CMD_REMOVE, 32'h0);
        queue_command(CMD_RESTART, 32'h0);
        queue_command(CMD_REMOVE, 32'h0);
        queue_command(CMD_INSERT, 32'h5555_5555);
        queue_command(CMD_REPLACE, 32'h5555_5555);
        queue_command(CMD_NEXT, 32'h0);
        queue_command(CMD_POP_FRONT, 32'h0);
        queue_command(CMD_INSERT, 32'h7FFF_FFFF);
        queue_command(CMD_PEEK_BACK, 32'h0);
        queue_command(4'((1 << CMD_W) - 1), 32'hFFFF_FFFF);
        queue_command(4'(CMD_READ + 1), 32'h0);

        // Random part: bursts that lean toward filling, draining or walking the
        // cursor, so the deque often reaches full and empty with the cursor
        // anywhere. Words favor all zeros and all ones now and then.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            mode = burst_mode_t'($urandom_range(MODE_MIXED));
            repeat ($urandom_range(8, 40))
            begin
                op = pick_op(mode);
                roll = $urandom_range(9);
                word = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : 32'($urandom);
                queue_command(op, word);
                if (op <= CMD_READ)
                    counted = counted + 1;
            end
        end
        commands_total = pending_commands.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled away from the active edge so the driver's updates have settled.
        while (pending_commands.size() != 0 || start || predicted_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
